@@ sv/f32as_pkg.sv @@
// ----------------------------------------------------------------------------
// f32as_pkg
// shared constants and helpers for the single precision add/sub pipeline
// ----------------------------------------------------------------------------
package f32as_pkg;

    localparam int EXP_W  = 8;
    localparam int FRAC_W = 23;
    localparam int SIG_W  = FRAC_W + 1;
    localparam int LZ_W   = 5;
    localparam int XEXP_W = EXP_W + 2;

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_SUB = 1'b1;

    localparam logic [SIG_W-1:0] HIDDEN_ONE = 24'h80_0000;

    // leading zeros of a 24 bit significand, nonzero input assumed
    function automatic logic [LZ_W-1:0] lzc24(input logic [SIG_W-1:0] v);
        logic [LZ_W-1:0] n;
        logic            found;
        n     = '0;
        found = 1'b0;
        for (int k = SIG_W - 1; k >= 0; k--) begin
            if (!found && v[k]) begin
                found = 1'b1;
                n     = LZ_W'(SIG_W - 1 - k);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/float32_add_sub_truncating.sv @@
// ----------------------------------------------------------------------------
// float32_add_sub_truncating
// single precision add/subtract, truncating, no special values, four stages
// ----------------------------------------------------------------------------
// channel  | direction | tdata                      | tuser
// s_axis   | in        | [31:0] a_bits [63:32] b_bits | [0] func
// m_axis   | out       | [31:0] sum_bits            | [0] exp_range_error
//
// one item per cycle while the output is not stalled, four register stages r1 to r4, output taken from r4
// the four stages share one enable: they advance when the output is empty or taken
// a stall on the output holds every stage, so the input is not ready
// synchronous active low reset clears the valid bits only
module float32_add_sub_truncating (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // a_bits, b_bits
    input  logic [0:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sum_bits
    output logic [0:0]  m_axis_tuser    // exp_range_error
);
    import f32as_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: sign reduction and operand ordering
    logic             s1_is_add, s1_sign, s1_swap, s1_xa;
    logic [31:0]      s1_x, s1_y, s1_big, s1_small;
    logic             r1_is_add, r1_sign;
    logic [EXP_W-1:0] r1_exp, r1_sh;
    logic [SIG_W-1:0] r1_bsig, r1_ssig;

    // stage 2: alignment and magnitude add or subtract
    logic [SIG_W-1:0] s2_shifted;
    logic             s2_borrow;
    logic [SIG_W:0]   s2_res;
    logic             r2_is_add, r2_sign, r2_borrow, r2_zero;
    logic [EXP_W-1:0] r2_exp;
    logic [SIG_W:0]   r2_res;

    // stage 3: leading zero count
    logic             r3_is_add, r3_sign, r3_borrow, r3_zero;
    logic [EXP_W-1:0] r3_exp;
    logic [SIG_W:0]   r3_res;
    logic [LZ_W-1:0]  r3_lz;

    // stage 4: normalize and pack
    logic [XEXP_W-1:0] n_exp;
    logic [SIG_W-1:0]  n_sig;
    logic              n_sign;
    logic [31:0]       r4_bits;
    logic              r4_err;

    assign en            = !r_v4 || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        s1_is_add = ((s_axis_tdata[31] == s_axis_tdata[63]) ^ (s_axis_tuser[0] == FUNC_SUB));
        s1_xa     = s1_is_add || !s_axis_tdata[31];
        s1_x      = s1_xa ? s_axis_tdata[31:0] : s_axis_tdata[63:32];
        s1_y      = s1_xa ? s_axis_tdata[63:32] : s_axis_tdata[31:0];
        if (s1_is_add) begin
            s1_swap = s1_x[30:23] < s1_y[30:23];
        end else begin
            s1_swap = (s1_x[30:23] < s1_y[30:23]) ||
                      ((s1_x[30:23] == s1_y[30:23]) && (s1_x[22:0] < s1_y[22:0]));
        end
        s1_big   = s1_swap ? s1_y : s1_x;
        s1_small = s1_swap ? s1_x : s1_y;
        s1_sign  = s1_is_add ? s_axis_tdata[31] : s1_swap;
    end

    always_comb begin
        s2_shifted = (r1_sh >= EXP_W'(SIG_W)) ? '0 : (r1_ssig >> r1_sh);
        s2_borrow  = (r1_sh != '0) && (r1_sh <= EXP_W'(SIG_W)) &&
                     r1_ssig[LZ_W'(r1_sh - 8'd1)];
        if (r1_is_add) begin
            s2_res = {1'b0, r1_bsig} + {1'b0, s2_shifted};
        end else begin
            s2_res = {1'b0, r1_bsig} - {1'b0, s2_shifted};
        end
    end

    always_comb begin
        n_sign = r3_sign;
        if (r3_is_add) begin
            if (r3_res[SIG_W]) begin
                n_sig = r3_res[SIG_W:1];
                n_exp = {2'b00, r3_exp} + XEXP_W'(1);
            end else begin
                n_sig = r3_res[SIG_W-1:0];
                n_exp = {2'b00, r3_exp};
            end
        end else if (r3_zero) begin
            n_sig  = '0;
            n_exp  = '0;
            n_sign = 1'b0;
        end else begin
            n_sig = r3_res[SIG_W-1:0] << r3_lz;
            n_exp = {2'b00, r3_exp} - {{(XEXP_W-LZ_W){1'b0}}, r3_lz};
            if (r3_borrow) begin
                n_sig = n_sig - SIG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_is_add <= s1_is_add;
            r1_sign   <= s1_sign;
            r1_exp    <= s1_big[30:23];
            r1_sh     <= s1_big[30:23] - s1_small[30:23];
            r1_bsig   <= {1'b1, s1_big[22:0]};
            r1_ssig   <= {1'b1, s1_small[22:0]};

            r2_is_add <= r1_is_add;
            r2_sign   <= r1_sign;
            r2_exp    <= r1_exp;
            r2_res    <= s2_res;
            r2_borrow <= s2_borrow && !r1_is_add;
            r2_zero   <= !r1_is_add && (r1_sh == '0) && (s2_res == '0);

            r3_is_add <= r2_is_add;
            r3_sign   <= r2_sign;
            r3_exp    <= r2_exp;
            r3_res    <= r2_res;
            r3_borrow <= r2_borrow;
            r3_zero   <= r2_zero;
            r3_lz     <= lzc24(r2_res[SIG_W-1:0]);

            r4_bits   <= {n_sign, n_exp[EXP_W-1:0], n_sig[FRAC_W-1:0]};
            r4_err    <= n_exp[XEXP_W-1] || n_exp[XEXP_W-2];
        end
    end

    assign m_axis_tvalid   = r_v4;
    assign m_axis_tdata    = r4_bits;
    assign m_axis_tuser[0] = r4_err;

endmodule

@@ sv/f32as_chk.sv @@
// ----------------------------------------------------------------------------
// f32as_chk
// port level checks for the add/sub pipeline, bound to the top level
// ----------------------------------------------------------------------------
module f32as_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled item changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("item lost in pipeline");

endmodule

bind float32_add_sub_truncating f32as_chk u_f32as_chk (.*);
